>>> hdl/doaot_pkg.sv
// Shared types and constants for the delayed-on / auto-off timer.
// Used by doaot_scale, doaot_ctrl and delayed_on_auto_off_timer; no dependencies.
`default_nettype none

package doaot_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int OPCODE_W    = 3;
   localparam int OPERAND_W   = 32;
   localparam int DURATION_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 8;

   // request opcodes (5 to 7 carry no meaning)
   localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ON         = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ON_FOR     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_ON_PERCENT = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_OFF        = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_ON_DELAY  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_OFF_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_DURATION     = 2'd2;

   // percentage limits
   localparam logic [OPERAND_W-1:0] PCT_MIN = 32'd1;
   localparam logic [OPERAND_W-1:0] PCT_MAX = 32'd100;
   localparam int PCT_W = 7;

   // divide by 100: q = (d * DIV100_MUL) >> DIV100_SHIFT, exact for any 32-bit d
   localparam logic [31:0] DIV100_MUL   = 32'd2748779070;
   localparam int          DIV100_SHIFT = 38;
   localparam int          QUOT_W       = 64 - DIV100_SHIFT;
   localparam int          REM_W        = 7;
   localparam logic [31:0] HUNDRED      = 32'd100;

   // remainder product / 100: exact for values below 43690
   localparam int           LO_W      = REM_W + PCT_W;
   localparam logic [12:0]  REM_MUL   = 13'd5243;
   localparam int           REM_SHIFT = 19;
   localparam int           LO_PROD_W = LO_W + 13;
   localparam int           HI_W      = QUOT_W + PCT_W;

   typedef struct packed {
      logic [DURATION_W-1:0] power_on_delay;
      logic                  auto_off_enable;
      logic [DURATION_W-1:0] on_duration;
   } cfg_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic                  pct_ok;
      logic [DURATION_W-1:0] duration;
   } item_type;

   // output_on sits in the lowest bit
   typedef struct packed {
      logic auto_off_event;
      logic pending_on;
      logic output_on;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/doaot_scale.sv
// Request pipeline that works out the one-time duration for on-for and on-percent.
// Depends on doaot_pkg; feeds doaot_ctrl.
`default_nettype none

module doaot_scale import doaot_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [OPCODE_W-1:0]  in_opcode,
   input  logic [OPERAND_W-1:0] in_operand,
   output logic                 out_valid,
   input  logic                 out_ready,
   output item_type             out_item
);

   logic [3:0] valid_ff, valid_in;
   logic [3:0] stage_ready;

   logic [OPCODE_W-1:0]  s0_opcode_ff, s1_opcode_ff, s2_opcode_ff, s3_opcode_ff;
   logic [OPERAND_W-1:0] s0_operand_ff, s1_operand_ff, s2_operand_ff, s3_operand_ff;
   logic [63:0]          s1_prod_ff, s1_prod_in;
   logic [QUOT_W-1:0]    s2_quot_ff, quot;
   logic [REM_W-1:0]     s2_rem_ff, s2_rem_in;
   logic [31:0]          rem_full;
   logic [HI_W-1:0]      s3_hi_ff, s3_hi_in;
   logic [LO_W-1:0]      s3_lo_ff, s3_lo_in;
   logic [PCT_W-1:0]     pct;
   logic [LO_PROD_W-1:0] lo_prod;
   logic [HI_W-1:0]      scaled;

   // a stage takes new data when empty or when its contents move on
   assign stage_ready[3] = !valid_ff[3] || out_ready;
   assign stage_ready[2] = !valid_ff[2] || stage_ready[3];
   assign stage_ready[1] = !valid_ff[1] || stage_ready[2];
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];
   assign in_ready       = stage_ready[0];

   always_comb begin
      valid_in[0] = stage_ready[0] ? in_valid : valid_ff[0];
      valid_in[1] = stage_ready[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = stage_ready[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = stage_ready[3] ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // on_duration = 100 * quot + rem, then scaled = quot * p + (rem * p) / 100
   assign s1_prod_in = 64'(cfg.on_duration) * 64'(DIV100_MUL);
   assign quot       = s1_prod_ff[63:DIV100_SHIFT];
   assign rem_full   = cfg.on_duration - 32'(32'(quot) * HUNDRED);
   assign s2_rem_in  = rem_full[REM_W-1:0];
   assign pct        = s2_operand_ff[PCT_W-1:0];
   assign s3_hi_in   = HI_W'(s2_quot_ff) * HI_W'(pct);
   assign s3_lo_in   = LO_W'(s2_rem_ff) * LO_W'(pct);
   assign lo_prod    = LO_PROD_W'(s3_lo_ff) * LO_PROD_W'(REM_MUL);
   assign scaled     = s3_hi_ff + HI_W'(lo_prod[LO_PROD_W-1:REM_SHIFT]);

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         s0_opcode_ff  <= in_opcode;
         s0_operand_ff <= in_operand;
      end
      if (stage_ready[1]) begin
         s1_opcode_ff  <= s0_opcode_ff;
         s1_operand_ff <= s0_operand_ff;
         s1_prod_ff    <= s1_prod_in;
      end
      if (stage_ready[2]) begin
         s2_opcode_ff  <= s1_opcode_ff;
         s2_operand_ff <= s1_operand_ff;
         s2_quot_ff    <= quot;
         s2_rem_ff     <= s2_rem_in;
      end
      if (stage_ready[3]) begin
         s3_opcode_ff  <= s2_opcode_ff;
         s3_operand_ff <= s2_operand_ff;
         s3_hi_ff      <= s3_hi_in;
         s3_lo_ff      <= s3_lo_in;
      end
   end

   assign out_valid       = valid_ff[3];
   assign out_item.opcode = s3_opcode_ff;
   assign out_item.pct_ok = (s3_operand_ff >= PCT_MIN) && (s3_operand_ff <= PCT_MAX);
   // scaled stays within on_duration for p of 100 or less; the top bit drops safely
   assign out_item.duration = (s3_opcode_ff == OP_ON_FOR) ? s3_operand_ff
                                                           : scaled[DURATION_W-1:0];

endmodule

`default_nettype wire

>>> hdl/doaot_ctrl.sv
// Timer state (phase, elapsed ticks, one-time duration) and the result register.
// Depends on doaot_pkg; takes prepared requests from doaot_scale.
`default_nettype none

module doaot_ctrl import doaot_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int CMP_W = (TIME_WIDTH > DURATION_W) ? TIME_WIDTH : DURATION_W;

   typedef enum logic [2:0] {
      PH_OFF  = 3'b001,
      PH_WAIT = 3'b010,
      PH_ON   = 3'b100
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]  elapsed_ff, elapsed_in, elapsed_inc;
   logic [DURATION_W-1:0]  once_ff, once_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   commit;
   logic                   event_hit;
   logic                   turn_on;
   logic [CMP_W-1:0]       elapsed_cmp;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign commit   = in_valid && in_ready;

   assign elapsed_inc = (elapsed_ff == {TIME_WIDTH{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;
   assign elapsed_cmp = CMP_W'(elapsed_inc);

   always_comb begin
      phase_in  = phase_ff;
      elapsed_in = elapsed_ff;
      once_in   = once_ff;
      event_hit = 1'b0;
      turn_on   = 1'b0;
      unique case (in_item.opcode)
         OP_TICK: begin
            elapsed_in = elapsed_inc;
            // auto-off wins over the one-time duration
            if (cfg.auto_off_enable && phase_ff == PH_ON) begin
               if (elapsed_cmp >= CMP_W'(cfg.on_duration)) begin
                  phase_in  = PH_OFF;
                  event_hit = 1'b1;
               end
            end else if (once_ff != '0 && phase_ff == PH_ON) begin
               if (elapsed_cmp >= CMP_W'(once_ff)) begin
                  once_in   = '0;
                  phase_in  = PH_OFF;
                  event_hit = 1'b1;
               end
            end
            if (phase_ff == PH_WAIT && elapsed_cmp >= CMP_W'(cfg.power_on_delay)) begin
               phase_in   = PH_ON;
               elapsed_in = '0;
            end
         end
         OP_ON: begin
            turn_on = 1'b1;
         end
         OP_ON_FOR: begin
            once_in = in_item.duration;
            turn_on = 1'b1;
         end
         OP_ON_PERCENT: begin
            if (in_item.pct_ok) begin
               once_in = in_item.duration;
               turn_on = 1'b1;
            end
         end
         OP_OFF: begin
            if (phase_ff == PH_ON) begin
               phase_in = PH_OFF;
            end
         end
         default: begin
         end
      endcase
      // on while pending restarts the delay; on while on keeps phase and count
      if (turn_on && phase_ff != PH_ON) begin
         elapsed_in = '0;
         phase_in   = (cfg.power_on_delay != '0) ? PH_WAIT : PH_ON;
      end
   end

   always_comb begin
      rsp_in.output_on      = (phase_in == PH_ON);
      rsp_in.pending_on     = (phase_in == PH_WAIT);
      rsp_in.auto_off_event = event_hit;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OFF;
         elapsed_ff   <= '0;
         once_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            phase_ff   <= phase_in;
            elapsed_ff <= elapsed_in;
            once_ff    <= once_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a timed switch-off always reports the output as off
   a_event_means_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.auto_off_event |-> !rsp_ff.output_on)
      else $error("auto-off event reported with output still on");

   // commands never raise the event
   a_event_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      commit && in_item.opcode != OP_TICK |=> !rsp_ff.auto_off_event)
      else $error("auto-off event from a command request");

   // switching on restarts the elapsed count
   a_on_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      commit && phase_ff != PH_ON && phase_in == PH_ON |=> elapsed_ff == '0)
      else $error("elapsed count not restarted on switch-on");

   // the count holds with no request; a request holds, grows or restarts it
   a_elapsed_monotonic: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(elapsed_ff))
      else $error("elapsed count moved without a request");

endmodule

`default_nettype wire

>>> hdl/delayed_on_auto_off_timer.sv
// A request passes scale stages s0 to s3, then the timer result register, to rsp_.
// Throughput: one request per cycle unless rsp_tready stalls; the percent scaling runs
// through a 4-stage multiply pipeline ahead of the registered timer state update.
// Reset (synchronous, active high): output off, no pending on, elapsed count and
// one-time duration zero, all configuration registers zero, pipeline empty.
// Top level: configuration registers, percent pipeline (doaot_scale), timer (doaot_ctrl).
`default_nettype none

module delayed_on_auto_off_timer import doaot_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] operand
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // [2:0] opcode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [0] output_on, [1] pending_on,
                                               // [2] auto_off_event, [7:3] zero
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type  cfg_ff;
   logic     mid_valid, mid_ready;
   item_type mid_item;
   rsp_type  rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_POWER_ON_DELAY:  cfg_ff.power_on_delay  <= csr_data;
            CSR_AUTO_OFF_ENABLE: cfg_ff.auto_off_enable <= csr_data[0];
            CSR_ON_DURATION:     cfg_ff.on_duration     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   doaot_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_opcode  (req_tuser),
      .in_operand (req_tdata),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_item   (mid_item)
   );

   doaot_ctrl #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {(RSP_TDATA_W - $bits(rsp_type))'(0), rsp_data};

endmodule

`default_nettype wire

>>> tb/delayed_on_auto_off_timer_tb.sv
// Self-checking bench for delayed_on_auto_off_timer: directed table, then randomised phases.
// Depends on doaot_pkg (widths, opcodes, register indexes, response layout) and the timer RTL.
`default_nettype none

module delayed_on_auto_off_timer_tb;
   import doaot_pkg::*;

   localparam int CLK_PERIOD       = 20;
   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RUN_LIMIT_CYCLES = 400000;
   localparam int NUM_PHASES       = 8;
   localparam int PHASE_ITEMS      = 200;
   localparam int REPORT_LIMIT     = 10;

   // opcodes and register index with no function
   localparam logic [OPCODE_W-1:0]    OP_RSVD5  = 3'd5;
   localparam logic [OPCODE_W-1:0]    OP_RSVD7  = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [OPERAND_W-1:0] ALL_ONES = '1;

   typedef enum logic [1:0] {SW_OFF, SW_ARMED, SW_LIVE} sw_phase_type;

   typedef struct packed {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] index;
      logic [OPCODE_W-1:0]    opcode;
      logic [OPERAND_W-1:0]   operand;
      logic                   known;
      rsp_type                want;
   } plan_row_type;

   localparam logic ROW_REQ = 1'b0;
   localparam logic ROW_CSR = 1'b1;
   localparam logic PREDICT = 1'b0;
   localparam logic KNOWN   = 1'b1;

   localparam rsp_type SEEN_OFF = 3'b000;
   localparam rsp_type SEEN_ON  = 3'b001;

   localparam int PLAN_LEN = 36;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   logic calm = 1'b0;

   // timer model state, same reset values as the block
   cfg_type              cfg_now       = '0;
   logic                 sw_on         = 1'b0;
   sw_phase_type         sw_phase      = SW_OFF;
   logic [DURATION_W-1:0] ticks_elapsed = '0;
   logic [DURATION_W-1:0] one_shot      = '0;

   rsp_type     expected_status [$];
   int unsigned fault_count = 0;
   int unsigned rsp_count   = 0;

   plan_row_type plan [PLAN_LEN] = '{
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    KNOWN,   SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON,         ALL_ONES, KNOWN,   SEEN_ON},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    KNOWN,   SEEN_ON},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_FOR,     32'd2,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       ALL_ONES, PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_OFF,        32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_RSVD5,      ALL_ONES, PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_RSVD7,      32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_PERCENT, 32'd50,   PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_OFF,        32'd0,    PREDICT, SEEN_OFF},
      '{ROW_CSR, CSR_POWER_ON_DELAY,  OP_TICK,      32'd3,    PREDICT, SEEN_OFF},
      '{ROW_CSR, CSR_ON_DURATION,     OP_TICK,      ALL_ONES, PREDICT, SEEN_OFF},
      '{ROW_CSR, CSR_AUTO_OFF_ENABLE, OP_TICK,      32'd0,    PREDICT, SEEN_OFF},
      '{ROW_CSR, CSR_SPARE,           OP_TICK,      ALL_ONES, PREDICT, SEEN_OFF},
      // out-of-range percentages are dropped
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_PERCENT, 32'd0,    KNOWN,   SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_PERCENT, 32'd101,  KNOWN,   SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_PERCENT, ALL_ONES, KNOWN,   SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_PERCENT, 32'd100,  PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    PREDICT, SEEN_OFF},
      // on while armed restarts the delay, off while armed keeps it armed
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON,         32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_OFF,        32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    PREDICT, SEEN_OFF},
      '{ROW_CSR, CSR_AUTO_OFF_ENABLE, OP_TICK,      32'd1,    PREDICT, SEEN_OFF},
      '{ROW_CSR, CSR_ON_DURATION,     OP_TICK,      32'd1,    PREDICT, SEEN_OFF},
      '{ROW_CSR, CSR_POWER_ON_DELAY,  OP_TICK,      32'd0,    PREDICT, SEEN_OFF},
      // auto-off wins over a long one-time duration
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON,         32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_FOR,     ALL_ONES, PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_PERCENT, 32'd1,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    PREDICT, SEEN_OFF},
      '{ROW_CSR, CSR_AUTO_OFF_ENABLE, OP_TICK,      32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_ON_FOR,     32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_TICK,       32'd0,    PREDICT, SEEN_OFF},
      '{ROW_REQ, CSR_POWER_ON_DELAY, OP_OFF,        32'd0,    PREDICT, SEEN_OFF}
   };

   delayed_on_auto_off_timer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * RUN_LIMIT_CYCLES);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void switch_on();
      if (sw_on)
         return;
      if (cfg_now.power_on_delay != 0 && sw_phase != SW_LIVE) begin
         ticks_elapsed = '0;
         sw_phase = SW_ARMED;
         return;
      end
      sw_phase = SW_LIVE;
      ticks_elapsed = '0;
      sw_on = 1'b1;
   endfunction

   function automatic void switch_off();
      if (!sw_on)
         return;
      sw_phase = SW_OFF;
      sw_on = 1'b0;
   endfunction

   function automatic logic advance_tick();
      logic fired;
      fired = 1'b0;
      if (ticks_elapsed != '1)
         ticks_elapsed = ticks_elapsed + 1'b1;
      if (cfg_now.auto_off_enable && sw_on) begin
         if (ticks_elapsed >= cfg_now.on_duration) begin
            switch_off();
            fired = 1'b1;
         end
      end else if (one_shot != 0 && sw_on) begin
         if (ticks_elapsed >= one_shot) begin
            one_shot = '0;
            switch_off();
            fired = 1'b1;
         end
      end
      if (sw_phase == SW_ARMED && ticks_elapsed >= cfg_now.power_on_delay) begin
         sw_phase = SW_LIVE;
         switch_on();
      end
      return fired;
   endfunction

   function automatic rsp_type timer_predict(input logic [OPCODE_W-1:0] op,
                                             input logic [OPERAND_W-1:0] arg);
      rsp_type     status;
      logic [63:0] scaled;
      status = '0;
      case (op)
         OP_TICK: status.auto_off_event = advance_tick();
         OP_ON: switch_on();
         OP_ON_FOR: begin
            one_shot = arg;
            switch_on();
         end
         OP_ON_PERCENT: begin
            if (arg >= PCT_MIN && arg <= PCT_MAX) begin
               scaled = (64'(cfg_now.on_duration) * 64'(arg)) / 64'(HUNDRED);
               one_shot = scaled[DURATION_W-1:0];
               switch_on();
            end
         end
         OP_OFF: switch_off();
         default: ;
      endcase
      status.output_on  = sw_on;
      status.pending_on = (sw_phase == SW_ARMED);
      return status;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_POWER_ON_DELAY:  cfg_now.power_on_delay  = value;
         CSR_AUTO_OFF_ENABLE: cfg_now.auto_off_enable = value[0];
         CSR_ON_DURATION:     cfg_now.on_duration     = value;
         default: ;
      endcase
   endfunction

   function automatic logic [DURATION_W-1:0] pick_span(input int unsigned top);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom;
         default: return $urandom_range(1, top);
      endcase
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   // called at a rising edge, returns at the edge that takes the request
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [OPERAND_W-1:0] arg,
                               input logic known, input rsp_type want);
      rsp_type guess;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= arg;
      @(negedge clock);
      while (req_tready !== 1'b1)
         @(negedge clock);
      guess = timer_predict(op, arg);
      expected_status.push_back(known ? want : guess);
      @(posedge clock);
   endtask

   // leaves csr_valid high, the caller lowers it
   task automatic program_csr(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      while (csr_ready !== 1'b1)
         @(negedge clock);
      apply_csr(idx, value);
      @(posedge clock);
   endtask

   task automatic maybe_pause();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic wait_settled();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side back-pressure in bursts
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (reset || calm) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // inputs only move at rising edges, so valid and ready seen here decide the next edge
   always @(negedge clock) begin : rsp_check
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         seen = rsp_tdata[2:0];
         rsp_count++;
         if (expected_status.size() == 0) begin
            note_fault($sformatf("response %0d arrived with nothing outstanding: %h",
                                 rsp_count, rsp_tdata));
         end else begin
            want = expected_status.pop_front();
            if (seen.output_on !== want.output_on || seen.pending_on !== want.pending_on ||
                seen.auto_off_event !== want.auto_off_event || rsp_tdata[7:3] !== '0) begin
               note_fault($sformatf(
                  "response %0d: want on=%b pend=%b ev=%b got on=%b pend=%b ev=%b pad=%h",
                  rsp_count, want.output_on, want.pending_on, want.auto_off_event,
                  seen.output_on, seen.pending_on, seen.auto_off_event, rsp_tdata[7:3]));
            end
         end
      end
   end

   initial begin : stimulus
      logic                  prev_csr;
      logic [OPCODE_W-1:0]   op;
      logic [OPERAND_W-1:0]  arg;
      int unsigned           roll;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_csr = 1'b0;
      for (int r = 0; r < PLAN_LEN; r++) begin
         if (plan[r].is_csr) begin
            if (!prev_csr)
               wait_settled();
            program_csr(plan[r].index, plan[r].operand);
         end else begin
            if (prev_csr)
               csr_valid <= 1'b0;
            send_request(plan[r].opcode, plan[r].operand, plan[r].known, plan[r].want);
            maybe_pause();
         end
         prev_csr = plan[r].is_csr;
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_settled();
         calm <= (ph % 3 == 2) || (ph == NUM_PHASES - 1);
         case (ph)
            0: begin
               program_csr(CSR_POWER_ON_DELAY, '0);
               program_csr(CSR_AUTO_OFF_ENABLE, '0);
               program_csr(CSR_ON_DURATION, '0);
            end
            1: begin
               program_csr(CSR_POWER_ON_DELAY, '1);
               program_csr(CSR_AUTO_OFF_ENABLE, 32'd1);
               program_csr(CSR_ON_DURATION, '1);
            end
            default: begin
               program_csr(CSR_ON_DURATION, pick_span(25));
               program_csr(CSR_AUTO_OFF_ENABLE, $urandom);
               program_csr(CSR_POWER_ON_DELAY, pick_span(5));
            end
         endcase
         if ($urandom_range(0, 1) == 0)
            program_csr(CSR_SPARE, $urandom);
         csr_valid <= 1'b0;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            arg  = $urandom;
            if (roll < 50) begin
               op = OP_TICK;
            end else if (roll < 60) begin
               op = OP_ON;
            end else if (roll < 70) begin
               op = OP_ON_FOR;
               if ($urandom_range(0, 7) != 0)
                  arg = $urandom_range(0, 12);
            end else if (roll < 80) begin
               op = OP_ON_PERCENT;
               case ($urandom_range(0, 9))
                  0: arg = '0;
                  1: arg = $urandom_range(101, 300);
                  2: arg = $urandom;
                  default: arg = $urandom_range(1, 100);
               endcase
            end else if (roll < 92) begin
               op = OP_OFF;
            end else begin
               op = OP_RSVD5 + 3'($urandom_range(0, OP_RSVD7 - OP_RSVD5));
            end
            send_request(op, arg, PREDICT, SEEN_OFF);
            maybe_pause();
         end
      end

      wait_settled();
      if (fault_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
